/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/pibd_pkg.sv */
// Package with the word types and constants of the connection burst detector.
`default_nettype none

package pibd_pkg;

	localparam logic [15:0] WATCHED_PORT   = 16'd22;
	localparam logic [15:0] DEFAULT_LIMIT  = 16'd5;
	localparam logic [63:0] DEFAULT_WINDOW = 64'd300_000_000_000;
	localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

	localparam logic [1:0] KIND_FIRST  = 2'd0;
	localparam logic [1:0] KIND_BURST  = 2'd1;
	localparam logic [1:0] KIND_SINGLE = 2'd2;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_LIMIT  = 2'd1;
	localparam logic [1:0] REG_WINDOW = 2'd2;

	localparam int CFG_DATA_W = 48;

	typedef struct packed {
		logic [31:0] remote_ip;
		logic [15:0] dest_port;
		logic [63:0] timestamp;
	} in_word_t;

	typedef struct packed {
		logic [31:0] source_ip;
		logic [1:0]  alert_kind;
		logic [15:0] attempt_count;
		logic [63:0] first_seen;
		logic [63:0] last_seen;
	} out_word_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] ip;
		logic [15:0] count;
		logic [63:0] first;
		logic [63:0] window;
	} entry_t;

endpackage

`default_nettype wire

/* rtl/per_ip_connection_burst_detector.sv */
// Per-address connection burst detector: lookup table, update logic and result register.
//
// Input channel in_valid/in_stall carries one connection event word (remote_ip,
// dest_port, timestamp). Output channel out_valid/out_stall carries one alert word.
// The configuration channel cfg_valid/cfg_ready writes enable, limit and window by
// index; it is always ready and is meant to be written while the block is idle.
// An event that is disabled or not for port 22 is taken in idle and gives no word.
// A tracked event passes three steps: the table read at acceptance, a compare state
// for tag and window age, and an update state that writes the entry back and loads
// the result register. No new event is taken until the update is done and the
// block is back in idle, as each event is a read-modify-write of its table entry.
// After reset the table is swept once, entry by entry, to clear its valid bits;
// in_stall stays high during the sweep.
// While the receiver stalls, the result word holds; a new event may still be taken,
// but its update waits until the held word has been delivered.
// TABLE_DEPTH must be a power of two.
`default_nettype none

module per_ip_connection_burst_detector #(
	parameter int TABLE_DEPTH = 4096
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  pibd_pkg::in_word_t             in_data,
	output logic                           out_valid,
	input  wire                            out_stall,
	output pibd_pkg::out_word_t            out_data,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [1:0]                     cfg_index,
	input  wire  [pibd_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_CMP   = 2'd2;
	localparam logic [1:0] ST_UPD   = 2'd3;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] clr_idx_q;

	logic        enable_q;
	logic [15:0] limit_q;
	logic [47:0] window_q;

	pibd_pkg::entry_t mem [TABLE_DEPTH];
	pibd_pkg::entry_t rd_q;
	pibd_pkg::entry_t mem_wdata;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;

	logic [IDX_W-1:0] slot;
	logic             in_acc;
	logic             tracked;

	logic [IDX_W-1:0] slot_s1;
	logic [31:0]      ip_s1;
	logic [63:0]      now_s1;

	logic             hit_s2;
	logic [15:0]      cnt_s2;
	logic [63:0]      first_s2;
	logic [63:0]      window_s2;

	logic [63:0] win_len;
	logic [63:0] elapsed;
	logic        expired;
	logic [15:0] limit;
	logic [15:0] cnt_inc;
	logic        burst;
	logic        upd_go;

	pibd_pkg::out_word_t out_q;
	logic                out_valid_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign tracked   = enable_q && (in_data.dest_port == pibd_pkg::WATCHED_PORT);
	assign slot      = IDX_W'(in_data.remote_ip ^ (in_data.remote_ip >> 16));

	assign win_len = (window_q == '0) ? pibd_pkg::DEFAULT_WINDOW : {16'd0, window_q};
	assign elapsed = now_s1 - rd_q.window;
	assign expired = elapsed > win_len;

	assign limit   = (limit_q == '0) ? pibd_pkg::DEFAULT_LIMIT : limit_q;
	assign cnt_inc = (cnt_s2 == pibd_pkg::COUNT_MAX) ? cnt_s2 : cnt_s2 + 16'd1;
	assign burst   = cnt_inc >= limit;
	assign upd_go  = (state_q == ST_UPD) && (!out_valid_q || !out_stall);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_s1;
		mem_wdata = '0;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
		end else if (upd_go) begin
			mem_we          = 1'b1;
			mem_wdata.valid = 1'b1;
			mem_wdata.ip    = ip_s1;
			if (hit_s2) begin
				mem_wdata.count  = burst ? 16'd0 : cnt_inc;
				mem_wdata.first  = first_s2;
				mem_wdata.window = burst ? now_s1 : window_s2;
			end else begin
				mem_wdata.count  = 16'd0;
				mem_wdata.first  = now_s1;
				mem_wdata.window = now_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (in_acc && tracked)
			rd_q <= mem[slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			limit_q  <= '0;
			window_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pibd_pkg::REG_ENABLE: enable_q <= cfg_data[0];
				pibd_pkg::REG_LIMIT:  limit_q  <= cfg_data[15:0];
				pibd_pkg::REG_WINDOW: window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == LAST_IDX)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc && tracked)
						state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_go)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			slot_s1 <= slot;
			ip_s1   <= in_data.remote_ip;
			now_s1  <= in_data.timestamp;
		end
		if (state_q == ST_CMP) begin
			hit_s2    <= rd_q.valid && (rd_q.ip == ip_s1);
			cnt_s2    <= expired ? 16'd0 : rd_q.count;
			first_s2  <= expired ? now_s1 : rd_q.first;
			window_s2 <= expired ? now_s1 : rd_q.window;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			out_q.source_ip <= ip_s1;
			out_q.last_seen <= now_s1;
			if (hit_s2) begin
				out_q.alert_kind    <= burst ? pibd_pkg::KIND_BURST : pibd_pkg::KIND_SINGLE;
				out_q.attempt_count <= cnt_inc;
				out_q.first_seen    <= first_s2;
			end else begin
				out_q.alert_kind    <= pibd_pkg::KIND_FIRST;
				out_q.attempt_count <= 16'd0;
				out_q.first_seen    <= now_s1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

/* rtl/pibd_checker.sv */
// Port checker for the connection burst detector and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module pibd_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 out_valid,
	input wire                 out_stall,
	input pibd_pkg::out_word_t out_data
);

	logic kind_known;
	logic first_word;
	logic first_ok;
	logic later_word;

	assign kind_known = (out_data.alert_kind == pibd_pkg::KIND_FIRST)
		|| (out_data.alert_kind == pibd_pkg::KIND_BURST)
		|| (out_data.alert_kind == pibd_pkg::KIND_SINGLE);
	assign first_word = out_valid && (out_data.alert_kind == pibd_pkg::KIND_FIRST);
	assign first_ok   = (out_data.attempt_count == 16'd0)
		&& (out_data.first_seen == out_data.last_seen);
	assign later_word = out_valid && (out_data.alert_kind != pibd_pkg::KIND_FIRST);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	`ASSERT_IMPLY(a_kind_code, clk, arst_n, out_valid, kind_known)
	`ASSERT_IMPLY(a_first_word, clk, arst_n, first_word, first_ok)
	`ASSERT_IMPLY(a_hit_count, clk, arst_n, later_word, out_data.attempt_count != 16'd0)

endmodule

bind per_ip_connection_burst_detector pibd_checker u_pibd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire

/* bench/pibd_alert_checker.sv */
`timescale 1ns / 100ps
// Checker that predicts the detector's alert words from the channel traffic and compares them.
module pibd_alert_checker
	import pibd_pkg::*;
#(
	parameter int TABLE_DEPTH = 4096
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  wire                   in_stall,
	input  in_word_t              in_data,
	input  wire                   out_valid,
	input  wire                   out_stall,
	input  out_word_t             out_data,
	input  wire                   cfg_valid,
	input  wire                   cfg_ready,
	input  wire  [1:0]            cfg_index,
	input  wire  [CFG_DATA_W-1:0] cfg_data,
	output int                    pending,
	output int                    mismatches
);

	localparam int SLOT_W = $clog2(TABLE_DEPTH);

	typedef struct {
		bit        live;
		bit [31:0] ip;
		bit [15:0] hits;
		bit [63:0] since;
		bit [63:0] win_start;
	} track_t;

	track_t    tracks[TABLE_DEPTH];
	bit        enable_r;
	bit [15:0] limit_r;
	bit [47:0] window_r;
	out_word_t expected_alerts[$];

	function automatic bit predict_alert(input in_word_t ev, output out_word_t al);
		bit [31:0]       hash;
		bit [SLOT_W-1:0] s;
		bit [63:0]       span;
		bit [15:0]       lim_v;
		bit [15:0]       cnt;
		al = '0;
		if (!enable_r || ev.dest_port != WATCHED_PORT) begin
			return 1'b0;
		end
		hash = ev.remote_ip ^ (ev.remote_ip >> 16);
		s = hash[SLOT_W-1:0];
		al.source_ip = ev.remote_ip;
		al.last_seen = ev.timestamp;
		if (!tracks[s].live || tracks[s].ip != ev.remote_ip) begin
			tracks[s].live = 1'b1;
			tracks[s].ip = ev.remote_ip;
			tracks[s].hits = '0;
			tracks[s].since = ev.timestamp;
			tracks[s].win_start = ev.timestamp;
			al.alert_kind = KIND_FIRST;
			al.attempt_count = '0;
			al.first_seen = ev.timestamp;
			return 1'b1;
		end
		span = (window_r != 0) ? {16'd0, window_r} : DEFAULT_WINDOW;
		if (ev.timestamp - tracks[s].win_start > span) begin
			tracks[s].hits = '0;
			tracks[s].win_start = ev.timestamp;
			tracks[s].since = ev.timestamp;
		end
		if (tracks[s].hits != COUNT_MAX) begin
			tracks[s].hits++;
		end
		cnt = tracks[s].hits;
		lim_v = (limit_r != 0) ? limit_r : DEFAULT_LIMIT;
		if (cnt >= lim_v) begin
			al.alert_kind = KIND_BURST;
			tracks[s].hits = '0;
			tracks[s].win_start = ev.timestamp;
		end else begin
			al.alert_kind = KIND_SINGLE;
		end
		al.attempt_count = cnt;
		al.first_seen = tracks[s].since;
		return 1'b1;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_alert(input out_word_t got, input out_word_t want);
		if (got.source_ip !== want.source_ip) begin
			flag_mismatch($sformatf("source_ip got %h, expected %h",
				got.source_ip, want.source_ip));
		end
		if (got.alert_kind !== want.alert_kind) begin
			flag_mismatch($sformatf("alert_kind of %h got %0d, expected %0d",
				want.source_ip, got.alert_kind, want.alert_kind));
		end
		if (got.attempt_count !== want.attempt_count) begin
			flag_mismatch($sformatf("attempt_count of %h got %0d, expected %0d",
				want.source_ip, got.attempt_count, want.attempt_count));
		end
		if (got.first_seen !== want.first_seen) begin
			flag_mismatch($sformatf("first_seen of %h got %h, expected %h",
				want.source_ip, got.first_seen, want.first_seen));
		end
		if (got.last_seen !== want.last_seen) begin
			flag_mismatch($sformatf("last_seen of %h got %h, expected %h",
				want.source_ip, got.last_seen, want.last_seen));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_word_t al;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				tracks[i].live = 1'b0;
			end
			enable_r = 1'b0;
			limit_r = '0;
			window_r = '0;
			expected_alerts.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ENABLE: begin
						enable_r = cfg_data[0];
					end
					REG_LIMIT: begin
						limit_r = cfg_data[15:0];
					end
					REG_WINDOW: begin
						window_r = cfg_data[47:0];
					end
					default: begin
					end
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_alerts.size() == 0) begin
					flag_mismatch($sformatf("alert word for %h with none expected",
						out_data.source_ip));
				end else begin
					check_alert(out_data, expected_alerts.pop_front());
				end
			end
			if (in_valid && !in_stall) begin
				if (predict_alert(in_data, al)) begin
					expected_alerts.push_back(al);
				end
			end
		end
		pending = expected_alerts.size();
	end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// Testbench top for the connection burst detector: stimulus, stalls, watchdog and verdict.
module tb;
	import pibd_pkg::*;

	localparam int          TABLE_DEPTH      = 4096;
	localparam int          IDLE_LIMIT       = 20000;
	localparam int          SETTLE_CYCLES    = 8;
	localparam int          EVENTS_PER_PHASE = 76;
	localparam logic [31:0] SLOT_TWIN        = 32'h0001_0001;
	localparam logic [31:0] PEER_A           = 32'h0A00_0001;
	localparam logic [31:0] PEER_C           = 32'h1234_5678;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_word_t              in_data;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_word_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [1:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int        pending;
	int        mismatches;
	int        idle_cycles;
	int        burst_left;
	int        stall_left;
	bit        stall_on;
	bit [63:0] now_ns;

	per_ip_connection_burst_detector #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	pibd_alert_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.mismatches(mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_on = ($urandom_range(0, 3) == 0);
			stall_left = stall_on ? $urandom_range(1, 8) : $urandom_range(1, 30);
		end
		stall_left--;
		out_stall <= stall_on;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("per_ip_connection_burst_detector test failed");
			$finish;
		end
	end

	task automatic send_event(input logic [31:0] ip, input logic [15:0] port,
		input logic [63:0] ts);
		in_data <= '{remote_ip: ip, dest_port: port, timestamp: ts};
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
		end
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic drain();
		quiesce();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic put_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic program_regs(input bit en, input logic [15:0] lim, input logic [47:0] win);
		put_reg(REG_ENABLE, CFG_DATA_W'(en));
		put_reg(REG_LIMIT, CFG_DATA_W'(lim));
		put_reg(REG_WINDOW, CFG_DATA_W'(win));
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input bit en, input logic [15:0] lim, input logic [47:0] win,
		input logic [63:0] stride, input int target);
		logic [31:0] pool[4];
		logic [31:0] ip;
		logic [15:0] port;
		int          counted;
		int          r;
		drain();
		program_regs(en, lim, win);
		for (int i = 0; i < 3; i++) begin
			pool[i] = $urandom;
		end
		pool[3] = pool[0] ^ SLOT_TWIN;
		counted = 0;
		while (counted < target) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				ip = pool[$urandom_range(0, 3)];
			end else if (r < 90) begin
				ip = pool[$urandom_range(0, 3)] ^ (SLOT_TWIN << $urandom_range(0, 11));
			end else begin
				ip = $urandom;
			end
			port = ($urandom_range(0, 9) == 0) ? 16'($urandom) : WATCHED_PORT;
			now_ns += {$urandom, $urandom} % (stride + 64'd1);
			if ($urandom_range(0, 49) == 0) begin
				now_ns += stride * 8;
			end
			send_event(ip, port, now_ns);
			if (!en || port == WATCHED_PORT) begin
				counted++;
			end
			if ($urandom_range(0, 59) == 0) begin
				quiesce();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_data = '0;
		idle_cycles = 0;
		burst_left = 1;
		now_ns = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// The monitor is off after reset, so a tracked port gives no word.
		send_event(PEER_A, WATCHED_PORT, 64'd0);
		drain();
		program_regs(1'b1, 16'd0, 48'd0);
		send_event(PEER_A, 16'd23, 64'd10);
		send_event(PEER_A, 16'd0, 64'd20);
		send_event(PEER_A, 16'hFFFF, 64'd30);
		send_event(32'h0000_0000, WATCHED_PORT, 64'd100);
		send_event(32'hFFFF_FFFF, WATCHED_PORT, 64'd200);
		// First attempt, four singles, a burst at the default limit, then a fresh count.
		for (int i = 0; i < 7; i++) begin
			send_event(PEER_A, WATCHED_PORT, 64'd300 + 64'(i));
		end
		// A different address in the same slot evicts the entry.
		send_event(PEER_A ^ SLOT_TWIN, WATCHED_PORT, 64'd400);
		send_event(PEER_A, WATCHED_PORT, 64'd500);
		// An age equal to the default window keeps it; one more nanosecond restarts it.
		send_event(PEER_A, WATCHED_PORT, 64'd500 + DEFAULT_WINDOW);
		send_event(PEER_A, WATCHED_PORT, 64'd501 + DEFAULT_WINDOW);
		// The age is taken modulo 2^64 across the timestamp wrap.
		send_event(PEER_C, WATCHED_PORT, 64'hFFFF_FFFF_FFFF_FFF6);
		send_event(32'h8765_4321, WATCHED_PORT, 64'hFFFF_FFFF_FFFF_FFFF);
		send_event(PEER_C, WATCHED_PORT, 64'd5);

		now_ns = 64'd1000;
		run_phase(1'b1, 16'd1, 48'd1000, 64'd1500, EVENTS_PER_PHASE);
		run_phase(1'b1, 16'd3, 48'hFFFF_FFFF_FFFF, 64'd1 << 40, EVENTS_PER_PHASE);
		run_phase(1'b1, 16'd0, 48'd0, 64'd40_000_000_000, EVENTS_PER_PHASE);
		run_phase(1'b0, 16'd7, 48'd500, 64'd300, 24);
		run_phase(1'b1, 16'hFFFF, 48'd2000, 64'd300, EVENTS_PER_PHASE);
		run_phase(1'b1, 16'd2, 48'd1, 64'd2, EVENTS_PER_PHASE);
		now_ns = 64'hFFFF_FFFF_FFFF_F000;
		run_phase(1'b1, 16'd4, 48'($urandom_range(1, 5000)), 64'd600, EVENTS_PER_PHASE);
		drain();

		if (mismatches == 0) begin
			$display("per_ip_connection_burst_detector test passed");
		end else begin
			$display("per_ip_connection_burst_detector test failed");
		end
		$finish;
	end

endmodule
